/* rtl/ndm_pkg.sv */
package ndm_pkg;

    // Field widths of one observation and of one summary.
    localparam int ADDR_W    = 48;
    localparam int GRADE_W   = 8;
    localparam int FLAG_N    = 6;
    localparam int COUNT_W   = 7;
    localparam int OUTCOME_W = 2;

    localparam int DEF_MAX_ENTRIES = 64;

    localparam logic [OUTCOME_W-1:0] OUTCOME_MERGED  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_ADDED   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED = 2'd2;

    // One table entry as it is held in the RAM.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [GRADE_W-1:0] grade;
        logic [FLAG_N-1:0]  flags;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Summary reported after every observation.
    typedef struct packed {
        logic [OUTCOME_W-1:0]           outcome;
        logic [COUNT_W-1:0]             entry_count;
        logic [FLAG_N-1:0][COUNT_W-1:0] flag_count;
        logic [GRADE_W-1:0]             top_grade;
        logic                           table_full;
    } t_summary;

endpackage

/* rtl/ndm_if.sv */
interface ndm_obs_if import ndm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  station_addr;
    logic [GRADE_W-1:0] grade;
    logic [FLAG_N-1:0]  flag_bits;

    modport source (output valid, output station_addr, output grade, output flag_bits,
                    input ready);
    modport sink   (input valid, input station_addr, input grade, input flag_bits,
                    output ready);
endinterface

interface ndm_sum_if import ndm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic [COUNT_W-1:0]   entry_count;
    logic [COUNT_W-1:0]   open_count;
    logic [COUNT_W-1:0]   no_mfp_count;
    logic [COUNT_W-1:0]   wps_count;
    logic [COUNT_W-1:0]   weak_count;
    logic [COUNT_W-1:0]   hidden_count;
    logic [COUNT_W-1:0]   modern_count;
    logic [GRADE_W-1:0]   top_grade;
    logic                 table_full;

    modport source (output valid, output outcome, output entry_count, output open_count,
                    output no_mfp_count, output wps_count, output weak_count,
                    output hidden_count, output modern_count, output top_grade,
                    output table_full, input ready);
    modport sink   (input valid, input outcome, input entry_count, input open_count,
                    input no_mfp_count, input wps_count, input weak_count,
                    input hidden_count, input modern_count, input top_grade,
                    input table_full, output ready);
endinterface

/* rtl/ndm_ram.sv */
module ndm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/network_dedup_merge_table.sv */
// Deduplicating merge table for observed network stations.
// Observations arrive on i_obs (station address, grade, six flags) and one
// summary per observation leaves on o_sum; a transfer happens when valid and
// ready are both high at a rising edge of i_clk.
// The block handles one observation at a time: i_obs.ready is high only while
// the sequencer is idle. The table RAM is searched one entry per cycle through
// a single address comparator, and each read comes from a registered RAM
// output. The summary of a new station is offered only after every held
// entry has been compared; a search ends at the first matching entry.
// i_obs.ready rises in the same cycle as the summary is offered.
// The summary sits in an output register, so a new observation is taken while
// the previous summary still waits; a finished summary is held back only if
// the one before it has not yet been transferred.
// A synchronous reset (i_rst_n low) empties the table, clears all counters, the
// worst grade and the sticky full flag. The RAM itself is not cleared: entries
// at or above the entry count are never read.
module network_dedup_merge_table import ndm_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input logic       i_clk,
    input logic       i_rst_n,
    ndm_obs_if.sink   i_obs,
    ndm_sum_if.source o_sum
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_HIT  = 3'd2;
    localparam logic [2:0] S_MISS = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic [GRADE_W-1:0]       r_grade, n_grade;
    logic [FLAG_N-1:0]        r_flags, n_flags;
    logic [CNT_W-1:0]         r_rd_idx, n_rd_idx;
    logic                     r_pend, n_pend;
    logic [IDX_W-1:0]         r_cmp_idx, n_cmp_idx;
    logic [GRADE_W-1:0]       r_ent_grade, n_ent_grade;
    logic [FLAG_N-1:0]        r_ent_flags, n_ent_flags;
    logic [CNT_W-1:0]         r_used, n_used;
    logic                     r_full, n_full;
    logic [CNT_W-1:0]         r_flag_cnt [FLAG_N];
    logic [CNT_W-1:0]         n_flag_cnt [FLAG_N];
    logic [GRADE_W-1:0]       r_max_grade, n_max_grade;
    logic [OUTCOME_W-1:0]     r_outcome, n_outcome;
    logic                     r_out_valid, n_out_valid;
    t_summary                 r_sum, n_sum;

    logic                     rd_en;
    logic                     hit_now;
    logic                     room;
    logic                     count_en;
    logic [FLAG_N-1:0]        set_mask;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    t_entry                   ram_wdata;
    logic [ENTRY_W-1:0]       ram_rdata;
    t_entry                   rd_ent;
    logic [GRADE_W-1:0]       merged_grade;

    ndm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_ent = t_entry'(ram_rdata);

    // The shared comparator: the entry read in the previous cycle against the
    // address of the observation in hand.
    assign hit_now = (r_state == S_SCAN) && r_pend && (rd_ent.addr == r_addr);

    // A read is issued while unread entries remain and no match has shown up.
    assign rd_en = (r_state == S_SCAN) && (r_rd_idx < r_used) && !hit_now;

    assign room         = (r_used != MAX_CNT);
    assign merged_grade = (r_grade > r_ent_grade) ? r_grade : r_ent_grade;

    // Writes happen only in the single update cycle of a hit or an append.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cmp_idx;
        ram_wdata = '{addr: r_addr, grade: r_grade, flags: r_flags};
        set_mask  = '0;
        count_en  = 1'b0;
        if (r_state == S_HIT) begin
            ram_we    = 1'b1;
            ram_wdata = '{addr: r_addr, grade: merged_grade, flags: r_ent_flags | r_flags};
            set_mask  = r_flags & ~r_ent_flags;
            count_en  = 1'b1;
        end else if (r_state == S_MISS && room) begin
            ram_we    = 1'b1;
            ram_waddr = r_used[IDX_W-1:0];
            set_mask  = r_flags;
            count_en  = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_grade     = r_grade;
        n_flags     = r_flags;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_cmp_idx   = r_cmp_idx;
        n_ent_grade = r_ent_grade;
        n_ent_flags = r_ent_flags;
        n_used      = r_used;
        n_full      = r_full;
        n_max_grade = r_max_grade;
        n_outcome   = r_outcome;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !o_sum.ready;

        for (int b = 0; b < FLAG_N; b++) begin
            n_flag_cnt[b] = r_flag_cnt[b];
            if (count_en && set_mask[b]) begin
                n_flag_cnt[b] = r_flag_cnt[b] + CNT_W'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_obs.valid) begin
                    n_addr   = i_obs.station_addr;
                    n_grade  = i_obs.grade;
                    n_flags  = i_obs.flag_bits;
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend    = rd_en;
                n_cmp_idx = r_rd_idx[IDX_W-1:0];
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                if (hit_now) begin
                    n_cmp_idx   = r_cmp_idx;
                    n_ent_grade = rd_ent.grade;
                    n_ent_flags = rd_ent.flags;
                    n_state     = S_HIT;
                end else if (!rd_en && !r_pend) begin
                    n_state = S_MISS;
                end
            end
            S_HIT: begin
                n_outcome = OUTCOME_MERGED;
                if (r_grade > r_max_grade) begin
                    n_max_grade = r_grade;
                end
                n_state = S_DONE;
            end
            S_MISS: begin
                if (room) begin
                    n_outcome = OUTCOME_ADDED;
                    n_used    = r_used + CNT_W'(1);
                    if (r_grade > r_max_grade) begin
                        n_max_grade = r_grade;
                    end
                end else begin
                    n_outcome = OUTCOME_DROPPED;
                    n_full    = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Wait until the output register is free or being emptied.
                if (!r_out_valid || o_sum.ready) begin
                    n_sum.outcome     = r_outcome;
                    n_sum.entry_count = COUNT_W'(r_used);
                    for (int b = 0; b < FLAG_N; b++) begin
                        n_sum.flag_count[b] = COUNT_W'(r_flag_cnt[b]);
                    end
                    n_sum.top_grade   = r_max_grade;
                    n_sum.table_full  = r_full;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_used      <= '0;
            r_full      <= 1'b0;
            r_max_grade <= '0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < FLAG_N; b++) begin
                r_flag_cnt[b] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_used      <= n_used;
            r_full      <= n_full;
            r_max_grade <= n_max_grade;
            r_out_valid <= n_out_valid;
            for (int b = 0; b < FLAG_N; b++) begin
                r_flag_cnt[b] <= n_flag_cnt[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_grade     <= n_grade;
        r_flags     <= n_flags;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_ent_grade <= n_ent_grade;
        r_ent_flags <= n_ent_flags;
        r_outcome   <= n_outcome;
        r_sum       <= n_sum;
    end

    assign i_obs.ready        = (r_state == S_IDLE);
    assign o_sum.valid        = r_out_valid;
    assign o_sum.outcome      = r_sum.outcome;
    assign o_sum.entry_count  = r_sum.entry_count;
    assign o_sum.open_count   = r_sum.flag_count[0];
    assign o_sum.no_mfp_count = r_sum.flag_count[1];
    assign o_sum.wps_count    = r_sum.flag_count[2];
    assign o_sum.weak_count   = r_sum.flag_count[3];
    assign o_sum.hidden_count = r_sum.flag_count[4];
    assign o_sum.modern_count = r_sum.flag_count[5];
    assign o_sum.top_grade    = r_sum.top_grade;
    assign o_sum.table_full   = r_sum.table_full;
endmodule

/* rtl/ndm_checker.sv */
module ndm_checker import ndm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [OUTCOME_W-1:0] i_outcome,
    input logic [COUNT_W-1:0]   i_entry_count,
    input logic [GRADE_W-1:0]   i_top_grade,
    input logic                 i_table_full
);
    logic               out_xfer;
    logic               r_have;
    logic [COUNT_W-1:0] r_last_count;
    logic               r_seen_full;

    assign out_xfer = i_out_valid && i_out_ready;

    // Remember what the last transferred summary showed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have       <= 1'b0;
            r_last_count <= '0;
            r_seen_full  <= 1'b0;
        end else if (out_xfer) begin
            r_have       <= 1'b1;
            r_last_count <= i_entry_count;
            r_seen_full  <= r_seen_full || i_table_full;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_entry_count)
            && $stable(i_outcome) && $stable(i_top_grade) && $stable(i_table_full))
        else $error("summary changed while stalled");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && (r_seen_full || i_outcome == OUTCOME_DROPPED) |-> i_table_full)
        else $error("table full flag not sticky");

    a_added_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_have && i_outcome == OUTCOME_ADDED
            |-> i_entry_count == r_last_count + COUNT_W'(1))
        else $error("append did not raise entry count by one");

    a_other_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_have && i_outcome != OUTCOME_ADDED |-> i_entry_count == r_last_count)
        else $error("entry count changed without an append");
endmodule

bind network_dedup_merge_table ndm_checker u_ndm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_sum.valid),
    .i_out_ready   (o_sum.ready),
    .i_outcome     (o_sum.outcome),
    .i_entry_count (o_sum.entry_count),
    .i_top_grade   (o_sum.top_grade),
    .i_table_full  (o_sum.table_full)
);

/* dv/network_dedup_merge_table_tb.sv */
`timescale 1ns / 100ps

module network_dedup_merge_table_tb;
    import ndm_pkg::*;

    // The table depth that the block is built with. The predictor models the
    // same depth, so the full-table behaviour lines up with the RTL.
    localparam int TABLE_DEPTH  = DEF_MAX_ENTRIES;
    localparam int RANDOM_ITEMS = 930;
    // Cycles without any transfer on either channel before the run is
    // abandoned. A full search, the sender gaps and the receiver stalls are all
    // far shorter than this.
    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;

    typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PATTERN} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    ndm_obs_if obs_if ();
    ndm_sum_if sum_if ();

    network_dedup_merge_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_obs   (obs_if.sink),
        .o_sum   (sum_if.source)
    );

    // Our own picture of the table: one queue slot per held station, in
    // the order in which the stations were first seen.
    logic [ADDR_W-1:0]  held_addr[$];
    logic [GRADE_W-1:0] held_grade[$];
    logic [FLAG_N-1:0]  held_flags[$];
    int unsigned        flag_tally[FLAG_N] = '{default: 0};
    logic [GRADE_W-1:0] peak_grade = '0;
    logic               overflow_seen = 1'b0;

    // Summaries that the block still owes us, oldest first.
    t_summary summary_q[$];

    // Stations used by the random traffic; some are held, some were dropped.
    logic [ADDR_W-1:0] station_pool[$];

    int       err_count = 0;
    int       burst_left = 0;
    int       quiet_cycles = 0;
    int       rx_cycle = 0;
    t_rx_mode rx_mode = RX_ALWAYS;

    // Clock; the single reset at the start of the run is driven further down.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one observation to the modelled table and return the summary
    // the block must report for it. A merge only counts flags that were not
    // already set on the entry, and a dropped observation leaves the worst
    // grade alone.
    function automatic t_summary merge_observation(input logic [ADDR_W-1:0] station,
                                                   input logic [GRADE_W-1:0] grade,
                                                   input logic [FLAG_N-1:0] flags);
        t_summary          s;
        int                hit;
        logic [FLAG_N-1:0] fresh;
        hit = -1;
        foreach (held_addr[i]) begin
            if (hit < 0 && held_addr[i] == station) hit = i;
        end
        if (hit >= 0) begin
            fresh = flags & ~held_flags[hit];
            if (grade > held_grade[hit]) held_grade[hit] = grade;
            held_flags[hit] = held_flags[hit] | flags;
            s.outcome = OUTCOME_MERGED;
        end else if (held_addr.size() >= TABLE_DEPTH) begin
            // No room: the observation is lost and the sticky flag is raised.
            fresh = '0;
            overflow_seen = 1'b1;
            s.outcome = OUTCOME_DROPPED;
        end else begin
            held_addr.push_back(station);
            held_grade.push_back(grade);
            held_flags.push_back(flags);
            fresh = flags;
            s.outcome = OUTCOME_ADDED;
        end
        for (int b = 0; b < FLAG_N; b++) begin
            if (fresh[b]) flag_tally[b]++;
            s.flag_count[b] = COUNT_W'(flag_tally[b]);
        end
        if (s.outcome != OUTCOME_DROPPED && grade > peak_grade) peak_grade = grade;
        s.entry_count = COUNT_W'(held_addr.size());
        s.top_grade   = peak_grade;
        s.table_full  = overflow_seen;
        return s;
    endfunction

    // A random station that is neither held nor already in the pool.
    function automatic logic [ADDR_W-1:0] unused_station();
        logic [ADDR_W-1:0] cand;
        bit                clash;
        do begin
            cand  = ADDR_W'({$urandom(), $urandom()});
            clash = 1'b0;
            foreach (held_addr[i]) if (held_addr[i] == cand) clash = 1'b1;
            foreach (station_pool[i]) if (station_pool[i] == cand) clash = 1'b1;
        end while (clash);
        return cand;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            err_count++;
        end
    endtask

    task automatic check_summary(input t_summary exp_sum);
        check_field("outcome",      exp_sum.outcome,       sum_if.outcome);
        check_field("entry_count",  exp_sum.entry_count,   sum_if.entry_count);
        check_field("open_count",   exp_sum.flag_count[0], sum_if.open_count);
        check_field("no_mfp_count", exp_sum.flag_count[1], sum_if.no_mfp_count);
        check_field("wps_count",    exp_sum.flag_count[2], sum_if.wps_count);
        check_field("weak_count",   exp_sum.flag_count[3], sum_if.weak_count);
        check_field("hidden_count", exp_sum.flag_count[4], sum_if.hidden_count);
        check_field("modern_count", exp_sum.flag_count[5], sum_if.modern_count);
        check_field("top_grade",    exp_sum.top_grade,     sum_if.top_grade);
        check_field("table_full",   exp_sum.table_full,    sum_if.table_full);
    endtask

    // Offer one observation and hold it until the block takes it. The sender
    // works in bursts; when a burst runs out, valid drops for a random gap,
    // sometimes long enough to span a whole search. Valid is left high after
    // a transfer, so back-to-back observations never lower and raise it in
    // the same time step.
    task automatic send_observation(input logic [ADDR_W-1:0] station,
                                    input logic [GRADE_W-1:0] grade,
                                    input logic [FLAG_N-1:0] flags);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            obs_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        obs_if.valid        <= 1'b1;
        obs_if.station_addr <= station;
        obs_if.grade        <= grade;
        obs_if.flag_bits    <= flags;
        @(posedge i_clk);
        while (!obs_if.ready) @(posedge i_clk);
        // The transfer happened at this edge; predict its summary now.
        summary_q.push_back(merge_observation(station, grade, flags));
        burst_left--;
    endtask

    // Hold the sender off until every summary owed has been transferred.
    task automatic wait_drained();
        obs_if.valid <= 1'b0;
        burst_left = 0;
        while (summary_q.size() != 0) @(posedge i_clk);
    endtask

    // Directed cases on an empty table: extreme addresses, grades and flag
    // patterns, a merge that raises the grade, one that must not lower it,
    // flags already set that must not be counted twice, each flag set on its
    // own, and addresses one bit away from a held one. Grades stay low here
    // so that the worst grade still has room to move in the random traffic.
    task automatic test_directed_merges();
        send_observation('0, 8'd0, 6'h00);
        send_observation('0, 8'd5, 6'h01);
        send_observation('0, 8'd2, 6'h01);
        send_observation({ADDR_W{1'b1}}, 8'd0, 6'h3F);
        send_observation({ADDR_W{1'b1}}, 8'd9, 6'h00);
        send_observation(48'h5555_5555_5555, 8'd3, 6'h2A);
        send_observation(48'hAAAA_AAAA_AAAA, 8'd7, 6'h15);
        for (int b = 0; b < FLAG_N; b++) begin
            send_observation('0, GRADE_W'(b), FLAG_N'(1 << b));
        end
        send_observation(48'h5555_5555_5555, 8'd12, 6'h3F);
        send_observation(48'h8000_0000_0000, 8'd1, 6'h00);
        send_observation(48'h0000_0000_0001, 8'd4, 6'h10);
        wait_drained();
    endtask

    // Mostly repeats of known stations with a steady trickle of new ones, so
    // the table fills part of the way through and the rest of the traffic
    // exercises merges and drops on a full table. Grades climb slowly and
    // flags are sparse, so the counts and the worst grade rise in steps. A
    // few fully random stations are mixed in as noise.
    task automatic test_random_traffic();
        logic [ADDR_W-1:0]  station;
        logic [GRADE_W-1:0] grade;
        logic [FLAG_N-1:0]  flags;
        int                 ceiling;
        station_pool = held_addr;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            ceiling = (16 + n / 3 > 254) ? 254 : 16 + n / 3;
            grade   = GRADE_W'($urandom_range(0, ceiling));
            flags   = ($urandom_range(0, 3) == 0) ? FLAG_N'($urandom())
                                                  : FLAG_N'($urandom() & $urandom() & $urandom());
            if ($urandom_range(0, 15) == 0) begin
                station = ADDR_W'({$urandom(), $urandom()});
            end else if ($urandom_range(0, 5) == 0) begin
                station = unused_station();
                station_pool.push_back(station);
            end else begin
                station = station_pool[$urandom_range(0, station_pool.size() - 1)];
            end
            send_observation(station, grade, flags);
            // One long pause mid-way lets the block run completely dry.
            if (n == RANDOM_ITEMS / 2) wait_drained();
        end
        wait_drained();
    endtask

    // Make sure the table is full, then check that a new station is dropped
    // even with the top grade (the worst grade must not follow it), that a
    // held station still merges, and that the full flag stays set.
    task automatic test_full_table();
        while (held_addr.size() < TABLE_DEPTH) begin
            send_observation(unused_station(), GRADE_W'($urandom_range(0, 254)),
                             FLAG_N'($urandom()));
        end
        send_observation(unused_station(), 8'd255, 6'h3F);
        send_observation(held_addr[0], 8'd255, 6'h3F);
        send_observation(held_addr[TABLE_DEPTH - 1], 8'd0, 6'h00);
        send_observation({ADDR_W{1'b1}}, 8'd128, 6'h20);
        send_observation(unused_station(), 8'd0, 6'h00);
        wait_drained();
    endtask

    // Receiver: ready follows one of several stall patterns, picked at random
    // in turn, including stretches where it never stalls.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_ALWAYS: sum_if.ready <= 1'b1;
            RX_MOSTLY: sum_if.ready <= ($urandom_range(0, 3) != 0);
            RX_SELDOM: sum_if.ready <= ($urandom_range(0, 3) == 0);
            default:   sum_if.ready <= ((rx_cycle / 4) % 8 != 0);
        endcase
    end

    // Every summary transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && sum_if.valid && sum_if.ready) begin
            if (summary_q.size() == 0) begin
                $error("summary transferred with no observation outstanding");
                err_count++;
            end else begin
                check_summary(summary_q.pop_front());
            end
        end
    end

    // Watchdog: give up if neither channel completes a transfer for too long.
    always @(posedge i_clk) begin
        if ((obs_if.valid && obs_if.ready) || (sum_if.valid && sum_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("network_dedup_merge_table_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        obs_if.valid        <= 1'b0;
        obs_if.station_addr <= '0;
        obs_if.grade        <= '0;
        obs_if.flag_bits    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_merges();
        test_random_traffic();
        test_full_table();

        // Allow a full search's worth of cycles for any stray summary.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("network_dedup_merge_table_tb: clean");
        end else begin
            $display("network_dedup_merge_table_tb: errors");
        end
        $finish;
    end

endmodule
